// ===== hdl/bss_pkg.sv =====
package bss_pkg;

   localparam int CntWidth    = 16;
   localparam int ValueWidth  = 8;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = 16;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_LOAD = 1'b1;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_DEBOUNCE_MS = 3'd0,
      CSR_HOLD_MS     = 3'd1,
      CSR_REPEAT_MS   = 3'd2,
      CSR_STEP_SINGLE = 3'd3,
      CSR_STEP_FAST   = 3'd4,
      CSR_RANGE_LO    = 3'd5,
      CSR_RANGE_HI    = 3'd6,
      CSR_UNUSED      = 3'd7
   } csr_index_type;

   localparam logic [CntWidth-1:0]   DEBOUNCE_MS_RST = 16'd50;
   localparam logic [CntWidth-1:0]   HOLD_MS_RST     = 16'd1000;
   localparam logic [CntWidth-1:0]   REPEAT_MS_RST   = 16'd500;
   localparam logic [ValueWidth-1:0] STEP_SINGLE_RST = 8'd1;
   localparam logic [ValueWidth-1:0] STEP_FAST_RST   = 8'd5;
   localparam logic [ValueWidth-1:0] RANGE_LO_RST    = 8'd40;
   localparam logic [ValueWidth-1:0] RANGE_HI_RST    = 8'd70;

   typedef struct packed {
      logic [CntWidth-1:0]   debounce_ms;
      logic [CntWidth-1:0]   hold_ms;
      logic [CntWidth-1:0]   repeat_ms;
      logic [ValueWidth-1:0] step_single;
      logic [ValueWidth-1:0] step_fast;
      logic [ValueWidth-1:0] range_lo;
      logic [ValueWidth-1:0] range_hi;
   } cfg_type;

   typedef struct packed {
      logic                  kind;
      logic                  button_level;
      logic [ValueWidth-1:0] new_target;
   } item_type;

   typedef struct packed {
      logic [ValueWidth-1:0] target;
      logic                  target_changed;
      logic                  pressed;
      logic                  fast_active;
   } result_type;

   function automatic logic [ValueWidth-1:0] apply_step(
      input logic [ValueWidth-1:0] value,
      input logic [ValueWidth-1:0] step,
      input logic [ValueWidth-1:0] vmin,
      input logic [ValueWidth-1:0] vmax
   );
      logic [ValueWidth:0] sum;
      sum = {1'b0, value} + {1'b0, step};
      if (sum > {1'b0, vmax}) begin
         return vmin;
      end
      return sum[ValueWidth-1:0];
   endfunction

   function automatic logic [CntWidth-1:0] sat_inc(input logic [CntWidth-1:0] v);
      if (v == {CntWidth{1'b1}}) begin
         return v;
      end
      return v + {{(CntWidth-1){1'b0}}, 1'b1};
   endfunction

endpackage

// ===== hdl/bss_csr.sv =====
module bss_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bss_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [bss_pkg::CsrDataWidth-1:0]     csr_wdata,
   output bss_pkg::cfg_type                     cfg
);

   bss_pkg::cfg_type cfg_ff;
   bss_pkg::cfg_type cfg_in;
   bss_pkg::csr_index_type idx;

   assign csr_ready = 1'b1;
   assign idx       = bss_pkg::csr_index_type'(csr_index);
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (idx)
            bss_pkg::CSR_DEBOUNCE_MS: cfg_in.debounce_ms = csr_wdata;
            bss_pkg::CSR_HOLD_MS:     cfg_in.hold_ms     = csr_wdata;
            bss_pkg::CSR_REPEAT_MS:   cfg_in.repeat_ms   = csr_wdata;
            bss_pkg::CSR_STEP_SINGLE: cfg_in.step_single = csr_wdata[bss_pkg::ValueWidth-1:0];
            bss_pkg::CSR_STEP_FAST:   cfg_in.step_fast   = csr_wdata[bss_pkg::ValueWidth-1:0];
            bss_pkg::CSR_RANGE_LO:    cfg_in.range_lo    = csr_wdata[bss_pkg::ValueWidth-1:0];
            bss_pkg::CSR_RANGE_HI:    cfg_in.range_hi    = csr_wdata[bss_pkg::ValueWidth-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms <= bss_pkg::DEBOUNCE_MS_RST;
         cfg_ff.hold_ms     <= bss_pkg::HOLD_MS_RST;
         cfg_ff.repeat_ms   <= bss_pkg::REPEAT_MS_RST;
         cfg_ff.step_single <= bss_pkg::STEP_SINGLE_RST;
         cfg_ff.step_fast   <= bss_pkg::STEP_FAST_RST;
         cfg_ff.range_lo    <= bss_pkg::RANGE_LO_RST;
         cfg_ff.range_hi    <= bss_pkg::RANGE_HI_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/bss_core.sv =====
module bss_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  bss_pkg::item_type   item,
   input  bss_pkg::cfg_type    cfg,
   output bss_pkg::result_type result
);

   logic                             last_raw_ff, last_raw_in;
   logic                             clean_ff, clean_in;
   logic                             press_active_ff, press_active_in;
   logic                             fast_ff, fast_in;
   logic [bss_pkg::CntWidth-1:0]     stable_ff, stable_in;
   logic [bss_pkg::CntWidth-1:0]     press_ff, press_in;
   logic [bss_pkg::CntWidth-1:0]     repeat_ff, repeat_in;
   logic [bss_pkg::ValueWidth-1:0]   target_ff, target_in;

   logic                             raw;
   logic                             edge_seen;
   logic                             press_edge;
   logic                             release_edge;
   logic                             rel_single;
   logic                             rel_fast;
   logic                             hold_cond;
   logic                             enter_fast;
   logic                             repeat_hit;
   logic                             step_a;
   logic                             step_b;
   logic                             changed;
   logic [bss_pkg::CntWidth-1:0]     rep_eff;
   logic [bss_pkg::ValueWidth-1:0]   amount_a;
   logic [bss_pkg::ValueWidth-1:0]   target_a;
   logic [bss_pkg::ValueWidth-1:0]   target_b;

   always_comb begin
      raw       = ~item.button_level;
      stable_in = bss_pkg::sat_inc(stable_ff);
      press_in  = bss_pkg::sat_inc(press_ff);
      last_raw_in = last_raw_ff;
      if (raw != last_raw_ff) begin
         last_raw_in = raw;
         stable_in   = '0;
      end

      edge_seen    = (stable_in >= cfg.debounce_ms) && (clean_ff != raw);
      clean_in     = edge_seen ? raw : clean_ff;
      press_edge   = edge_seen && raw;
      release_edge = edge_seen && !raw;

      rel_single = release_edge && (press_in < cfg.hold_ms);
      rel_fast   = release_edge && !(press_in < cfg.hold_ms) && !fast_ff;

      hold_cond  = !edge_seen && clean_ff && press_active_ff && (press_in >= cfg.hold_ms);
      enter_fast = hold_cond && !fast_ff;
      rep_eff    = enter_fast ? '0 : bss_pkg::sat_inc(repeat_ff);
      repeat_hit = hold_cond && (rep_eff >= cfg.repeat_ms);

      step_a   = rel_single || rel_fast || enter_fast || repeat_hit;
      step_b   = enter_fast && repeat_hit;
      amount_a = rel_single ? cfg.step_single : cfg.step_fast;
      target_a = step_a ? bss_pkg::apply_step(target_ff, amount_a, cfg.range_lo, cfg.range_hi)
                        : target_ff;
      target_b = step_b ? bss_pkg::apply_step(target_a, cfg.step_fast, cfg.range_lo,
                                              cfg.range_hi)
                        : target_a;

      repeat_in       = (enter_fast || repeat_hit) ? '0 : rep_eff;
      press_active_in = press_active_ff;
      fast_in         = fast_ff;
      if (press_edge) begin
         press_active_in = 1'b1;
         fast_in         = 1'b0;
         press_in        = '0;
      end else if (release_edge) begin
         press_active_in = 1'b0;
         fast_in         = 1'b0;
      end else if (enter_fast) begin
         fast_in = 1'b1;
      end
      target_in = target_b;
      changed   = step_a;

      // load items touch only the target
      if (item.kind == bss_pkg::REQ_LOAD) begin
         last_raw_in     = last_raw_ff;
         clean_in        = clean_ff;
         press_active_in = press_active_ff;
         fast_in         = fast_ff;
         stable_in       = stable_ff;
         press_in        = press_ff;
         repeat_in       = repeat_ff;
         target_in       = item.new_target;
         changed         = 1'b0;
      end

      result.target         = target_in;
      result.target_changed = changed;
      result.pressed        = clean_in;
      result.fast_active    = fast_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff     <= 1'b0;
         clean_ff        <= 1'b0;
         press_active_ff <= 1'b0;
         fast_ff         <= 1'b0;
         stable_ff       <= '0;
         press_ff        <= '0;
         repeat_ff       <= '0;
         target_ff       <= bss_pkg::RANGE_LO_RST;
      end else if (advance) begin
         last_raw_ff     <= last_raw_in;
         clean_ff        <= clean_in;
         press_active_ff <= press_active_in;
         fast_ff         <= fast_in;
         stable_ff       <= stable_in;
         press_ff        <= press_in;
         repeat_ff       <= repeat_in;
         target_ff       <= target_in;
      end
   end

endmodule

// ===== hdl/button_setpoint_stepper.sv =====
// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall req_type, req_button_level, req_new_target
// rsp       out        rsp_valid/rsp_stall rsp_target, rsp_target_changed, rsp_pressed,
//                                          rsp_fast_active
// csr       in         csr_valid/csr_ready csr_index, csr_wdata
//
// One item per cycle while the result is not stalled.
// The button state update and the target step sit between the input and result registers.
// Reset is synchronous: valid, core and CSR state resets, target to the wrap low default.
// A stalled result holds; the input stalls only while both stages are full and the
// result is stalled.
module button_setpoint_stepper (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_type,
   input  logic                                  req_button_level,
   input  logic [bss_pkg::ValueWidth-1:0]        req_new_target,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [bss_pkg::ValueWidth-1:0]        rsp_target,
   output logic                                  rsp_target_changed,
   output logic                                  rsp_pressed,
   output logic                                  rsp_fast_active,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bss_pkg::CsrIdxWidth-1:0]       csr_index,
   input  logic [bss_pkg::CsrDataWidth-1:0]      csr_wdata
);

   bss_pkg::cfg_type    cfg;
   bss_pkg::item_type   item_ff, item_in;
   bss_pkg::result_type out_ff, result;
   logic                in_valid_ff, in_valid_in;
   logic                out_valid_ff, out_valid_in;
   logic                out_load;
   logic                advance;
   logic                req_take;

   bss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bss_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_comb begin
      out_load  = !out_valid_ff || !rsp_stall;
      advance   = in_valid_ff && out_load;
      req_stall = in_valid_ff && !out_load;
      req_take  = req_valid && !req_stall;

      in_valid_in = req_take || (in_valid_ff && !advance);
      item_in.kind         = req_type;
      item_in.button_level = req_button_level;
      item_in.new_target   = req_new_target;

      out_valid_in = advance || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_target         = out_ff.target;
   assign rsp_target_changed = out_ff.target_changed;
   assign rsp_pressed        = out_ff.pressed;
   assign rsp_fast_active    = out_ff.fast_active;

endmodule
